[rtl/wrdp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrdp_pkg
// Shared types and constants of the RIFF/WAVE duration parser.
// ----------------------------------------------------------------------------
package wrdp_pkg;

    localparam int LENGTH_WIDTH = 32;
    localparam int LEN_FIELD_W  = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;
    localparam int POS_W        = LENGTH_WIDTH + 1;
    localparam int TOTAL_W      = 40;
    localparam int RATE_W       = 32;
    localparam int TICKS_W      = 20;
    localparam int SCALE_SHIFT  = 5;
    localparam int DVD_W        = TOTAL_W + SCALE_SHIFT;
    localparam int PROD_W       = DVD_W + TICKS_W;
    localparam int DUR_W        = 32;
    localparam int CNT_W        = $clog2(DVD_W);
    localparam int MIN_BYTES    = 32;

    localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(1000);

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [POS_W-1:0] POS_RIFF_LEN = POS_W'(7);
    localparam logic [POS_W-1:0] POS_WAVE     = POS_W'(11);
    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_SHORT   = 3'd1,
        STAT_BAD_SIG = 3'd2,
        STAT_NO_FMT  = 3'd3,
        STAT_NO_DATA = 3'd4
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [TOTAL_W-1:0]  total;
        logic [RATE_W-1:0]   rate;
    } job_t;

endpackage

[rtl/wav_riff_duration_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_riff_duration_parser_unit
// RIFF/WAVE image parser returning a status and the play time in ticks.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_        in   s_tvalid/s_tready      s_tdata[7:0] data_byte, s_tlast last
//  m_        out  m_tvalid/m_tready      m_tdata[2:0] status, [34:3] duration
//  cfg_      in   cfg_valid/cfg_ready    cfg_data ticks_per_second
//
//  Bytes are taken one per cycle; the front stalls only while the two-entry
//  job queue is full. Jobs are registered in the queue; a file with status ok
//  then runs through the back unit (45-step serial divide, 20-step shift-add
//  multiply, saturation) before its result is presented; other statuses skip
//  them. Synchronous active-low reset; the tick register returns to 1000.
// ----------------------------------------------------------------------------
module wav_riff_duration_parser_unit import wrdp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] data_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,    // [2:0] status, [34:3] duration_ticks
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TICKS_W-1:0] cfg_data
);

    logic [TICKS_W-1:0] ticks_reg;
    logic               fq_valid, fq_ready;
    job_t               fq_job;
    logic               qb_valid, qb_ready;
    job_t               qb_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            ticks_reg <= cfg_data;
        end
    end

    wrdp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    wrdp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    wrdp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ticks     (ticks_reg),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/wrdp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrdp_front
// Byte-wise chunk walker: signatures, fmt rate capture, data length sum.
// ----------------------------------------------------------------------------
module wrdp_front import wrdp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   eend_reg, eend_next;
    logic [63:0]        hs_reg, hs_next;
    logic [POS_W-1:0]   br_reg, br_next;
    logic               pend_reg, pend_next;
    logic [3:0]         fo_reg, fo_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic [1:0]         flags_reg, flags_next;
    logic [TOTAL_W-1:0] tot_reg, tot_next;
    logic [TOTAL_W:0]   tot_sum;
    logic [LEN_FIELD_W-1:0] len_old;
    logic               accept;
    status_t            status;

    assign s_tready  = job_ready;
    assign accept    = s_tvalid & s_tready;
    assign job_valid = accept & s_tlast;
    assign len_old   = hs_reg[32 +: LEN_FIELD_W];
    assign tot_sum   = {1'b0, tot_reg} + (TOTAL_W+1)'(len_old);

    always_comb begin
        pos_next   = pos_reg;
        eend_next  = eend_reg;
        br_next    = br_reg;
        pend_next  = pend_reg;
        fo_next    = fo_reg;
        rate_next  = rate_reg;
        flags_next = flags_reg;
        tot_next   = tot_reg;

        if (pend_reg) begin
            pend_next = 1'b0;
            if (pos_reg < eend_reg) begin
                br_next = POS_W'(len_old) + POS_W'(8);
                if (hs_reg[31:0] == TAG_FMT) begin
                    flags_next[1] = 1'b1;
                    fo_next       = 4'd0;
                    rate_next     = '0;
                end
                if (hs_reg[31:0] == TAG_DATA) begin
                    tot_next = tot_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_sum[TOTAL_W-1:0];
                end
            end
        end

        if (flags_next[1] && fo_next < 4'd12) begin
            if (fo_next >= 4'd8) begin
                case (fo_next[1:0])
                    2'd0:    rate_next[7:0]   = rate_next[7:0]   | s_tdata;
                    2'd1:    rate_next[15:8]  = rate_next[15:8]  | s_tdata;
                    2'd2:    rate_next[23:16] = rate_next[23:16] | s_tdata;
                    default: rate_next[31:24] = rate_next[31:24] | s_tdata;
                endcase
            end
            fo_next = fo_next + 4'd1;
        end

        hs_next = {s_tdata, hs_reg[63:8]};

        if (br_next != '0) begin
            br_next = br_next - POS_W'(1);
            if (br_next == '0) begin
                pend_next = 1'b1;
            end
        end

        if (pos_reg == POS_RIFF_LEN) begin
            flags_next[0] = (hs_next[31:0] == TAG_RIFF);
            eend_next     = POS_W'(hs_next[32 +: LEN_FIELD_W]) + POS_W'(8);
        end
        if (pos_reg == POS_WAVE) begin
            if (hs_next[63:32] != TAG_WAVE) begin
                flags_next[0] = 1'b0;
            end
            br_next = POS_W'(8);
        end

        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

        if (pos_next < POS_W'(MIN_BYTES)) begin
            status = STAT_SHORT;
        end else if (!flags_next[0]) begin
            status = STAT_BAD_SIG;
        end else if (!flags_next[1]) begin
            status = STAT_NO_FMT;
        end else if (tot_next == '0) begin
            status = STAT_NO_DATA;
        end else if (rate_next == '0) begin
            status = STAT_NO_FMT;
        end else begin
            status = STAT_OK;
        end
    end

    assign job.status = status;
    assign job.total  = tot_next;
    assign job.rate   = rate_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            pos_reg   <= '0;
            eend_reg  <= POS_MAX;
            hs_reg    <= '0;
            br_reg    <= '0;
            pend_reg  <= 1'b0;
            fo_reg    <= '0;
            rate_reg  <= '0;
            flags_reg <= '0;
            tot_reg   <= '0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            eend_reg  <= eend_next;
            hs_reg    <= hs_next;
            br_reg    <= br_next;
            pend_reg  <= pend_next;
            fo_reg    <= fo_next;
            rate_reg  <= rate_next;
            flags_reg <= flags_next;
            tot_reg   <= tot_next;
        end
    end

endmodule

[rtl/wrdp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrdp_queue
// Two-entry job queue between the parser front and the arithmetic back.
// ----------------------------------------------------------------------------
module wrdp_queue import wrdp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t       mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_job    = mem_reg[rd_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_push) begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop) begin
                rd_reg <= ~rd_reg;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

[rtl/wrdp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrdp_back
// Duration unit: bit-serial divide, shift-add multiply, saturate, result reg.
// ----------------------------------------------------------------------------
module wrdp_back import wrdp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [TICKS_W-1:0] ticks,
    input  logic               job_valid,
    output logic               job_ready,
    input  job_t               job,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata     // [2:0] status, [34:3] duration_ticks
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_FIN,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [RATE_W-1:0]   rem_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [PROD_W-1:0]   mcand_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [TICKS_W-1:0]  mplier_reg;
    logic [CNT_W-1:0]    cnt_reg;
    status_t             status_reg;
    logic [DUR_W-1:0]    dur_reg;
    logic                valid_reg;

    logic [RATE_W:0]     rem_sh;
    logic                ge;
    logic [RATE_W-1:0]   rem_new;
    logic [DVD_W-1:0]    dvd_new;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge       = (rem_sh >= {1'b0, rate_reg});
    assign rem_new  = ge ? RATE_W'(rem_sh - {1'b0, rate_reg}) : rem_sh[RATE_W-1:0];
    assign dvd_new  = {dvd_reg[DVD_W-2:0], ge};

    assign job_ready = (state_reg == S_IDLE);
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {5'd0, dur_reg, status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            valid_reg  <= 1'b0;
            cnt_reg    <= '0;
            status_reg <= STAT_OK;
            dur_reg    <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        status_reg <= job.status;
                        dvd_reg    <= {job.total, {SCALE_SHIFT{1'b0}}};
                        rem_reg    <= '0;
                        rate_reg   <= job.rate;
                        mplier_reg <= ticks;
                        cnt_reg    <= '0;
                        if (job.status == STAT_OK) begin
                            state_reg <= S_DIV;
                        end else begin
                            dur_reg   <= '0;
                            valid_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_new;
                    dvd_reg <= dvd_new;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                        mcand_reg <= PROD_W'(dvd_new);
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[TICKS_W-1:1]};
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(TICKS_W - 1)) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (acc_reg[PROD_W-1:SCALE_SHIFT+DUR_W] != '0) begin
                        dur_reg <= {DUR_W{1'b1}};
                    end else begin
                        dur_reg <= acc_reg[SCALE_SHIFT +: DUR_W];
                    end
                    valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    valid_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[bench/wav_riff_duration_parser_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_riff_duration_parser_unit_tb
// Streams wave file images byte by byte into the parser and compares every
// status/duration request on the result stream against an in-bench parser
// model. A short table of hand-built images comes first, followed by
// randomized images across several tick settings, with bursty input and
// receiver backpressure.
// ----------------------------------------------------------------------------
module wav_riff_duration_parser_unit_tb;
    import wrdp_pkg::*;

    localparam int N_DIR = 21;

    typedef struct packed {
        status_t     status;
        logic [31:0] ticks;
    } wav_result_t;

    typedef struct packed {
        logic [31:0] sig;
        logic [31:0] len;
        logic [7:0]  body;
    } chunk_spec_t;

    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic [31:0]        riff_sig;
        logic [31:0]        riff_len;
        logic [31:0]        wave_sig;
        chunk_spec_t        c0;
        chunk_spec_t        c1;
        chunk_spec_t        c2;
        logic [31:0]        rate;
        logic [7:0]         tail;
        logic [7:0]         cut;
        logic               fixed_exp;
        status_t            exp_status;
        logic [31:0]        exp_ticks;
    } image_spec_t;

    typedef enum {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_BLOCKS} ready_mode_t;

    localparam chunk_spec_t FMT16 = '{TAG_FMT, 32'd16, 8'd16};
    localparam chunk_spec_t NO_CK = '0;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;   // [7:0] data_byte
    logic               s_tlast   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [39:0]        m_tdata;          // [2:0] status, [34:3] duration_ticks
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [TICKS_W-1:0] cfg_data  = '0;

    wav_riff_duration_parser_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // parser model state
    logic [POS_W-1:0]   pos_cnt;
    logic [POS_W-1:0]   end_limit;
    logic [63:0]        hdr_window;
    logic [POS_W-1:0]   body_left;
    logic               hdr_due;
    logic [3:0]         fmt_idx;
    logic [RATE_W-1:0]  rate_acc;
    logic               sig_ok;
    logic               fmt_seen;
    logic [TOTAL_W-1:0] data_sum;
    logic [TICKS_W-1:0] tick_rate = TICKS_RESET;

    wav_result_t pending_durations[$];
    logic [7:0]  file_bytes[$];
    int          fail_cnt   = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;
    bit          gappy      = 1'b1;

    function automatic void clear_parse_state();
        pos_cnt    = '0;
        end_limit  = POS_MAX;
        hdr_window = '0;
        body_left  = '0;
        hdr_due    = 1'b0;
        fmt_idx    = '0;
        rate_acc   = '0;
        sig_ok     = 1'b0;
        fmt_seen   = 1'b0;
        data_sum   = '0;
    endfunction

    function automatic bit parse_wav_byte(input logic [7:0] b, input logic lst,
                                          output wav_result_t res);
        logic [POS_W-1:0]   pos;
        logic [31:0]        lo;
        logic [31:0]        hi;
        logic [TOTAL_W:0]   sum;
        logic [DVD_W-1:0]   quot;
        logic [79:0]        prod;
        pos = pos_cnt;
        res = '{STAT_OK, 32'd0};
        if (hdr_due) begin
            hdr_due = 1'b0;
            if (pos < end_limit) begin
                body_left = POS_W'(hdr_window[32 +: LEN_FIELD_W]) + POS_W'(8);
                if (hdr_window[31:0] == TAG_FMT) begin
                    fmt_seen = 1'b1;
                    fmt_idx  = '0;
                    rate_acc = '0;
                end
                if (hdr_window[31:0] == TAG_DATA) begin
                    sum      = {1'b0, data_sum} + (TOTAL_W + 1)'(hdr_window[32 +: LEN_FIELD_W]);
                    data_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                end
            end
        end
        if (fmt_seen && fmt_idx < 4'd12) begin
            if (fmt_idx >= 4'd8)
                rate_acc = rate_acc | (32'(b) << (8 * (int'(fmt_idx) - 8)));
            fmt_idx++;
        end
        hdr_window = {b, hdr_window[63:8]};
        lo = hdr_window[31:0];
        hi = hdr_window[63:32];
        if (body_left != '0) begin
            body_left--;
            if (body_left == '0)
                hdr_due = 1'b1;
        end
        if (pos == POS_RIFF_LEN) begin
            sig_ok    = (lo == TAG_RIFF);
            end_limit = POS_W'(hi[LEN_FIELD_W-1:0]) + POS_W'(8);
        end
        if (pos == POS_WAVE) begin
            if (hi != TAG_WAVE)
                sig_ok = 1'b0;
            body_left = POS_W'(8);
        end
        if (pos_cnt != POS_MAX)
            pos_cnt++;
        if (!lst)
            return 1'b0;
        if (pos_cnt < POS_W'(MIN_BYTES))
            res.status = STAT_SHORT;
        else if (!sig_ok)
            res.status = STAT_BAD_SIG;
        else if (!fmt_seen)
            res.status = STAT_NO_FMT;
        else if (data_sum == '0)
            res.status = STAT_NO_DATA;
        else if (rate_acc == '0)
            res.status = STAT_NO_FMT;
        else begin
            quot = {data_sum, 5'b0} / DVD_W'(rate_acc);
            prod = (80'(quot) * 80'(tick_rate)) >> SCALE_SHIFT;
            res.ticks = (|prod[79:32]) ? 32'hFFFF_FFFF : prod[31:0];
        end
        clear_parse_state();
        return 1'b1;
    endfunction

    function automatic chunk_spec_t ck(input logic [31:0] s, input logic [31:0] l,
                                       input int unsigned b);
        ck = '{s, l, 8'(b)};
    endfunction

    function automatic chunk_spec_t random_chunk(input logic [31:0] favored);
        chunk_spec_t c;
        c.sig = favored;
        if ($urandom_range(0, 9) >= 7) begin
            case ($urandom_range(0, 3))
                0:       c.sig = TAG_FMT;
                1:       c.sig = TAG_DATA;
                2:       c.sig = $urandom;
                default: c.sig = '0;
            endcase
        end
        if (c.sig == TAG_FMT)
            c.len = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 24)) : 32'd16;
        else
            c.len = $urandom_range(0, 40);
        c.body = c.len[7:0];
        // length field runs past the end of the image
        if ($urandom_range(0, 7) == 0) begin
            c.len  = $urandom;
            c.body = 8'($urandom_range(0, 12));
        end
        return c;
    endfunction

    function automatic void put32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void build_image(input image_spec_t sp);
        chunk_spec_t cl[3];
        int          rate_at;
        cl[0]   = sp.c0;
        cl[1]   = sp.c1;
        cl[2]   = sp.c2;
        rate_at = -1;
        file_bytes.delete();
        for (int c = 0; c < 3; c++)
            if (cl[c].sig == TAG_FMT)
                rate_at = c;
        put32(sp.riff_sig);
        put32(sp.riff_len);
        put32(sp.wave_sig);
        for (int c = 0; c < 3; c++) begin
            if (cl[c].sig != '0) begin
                put32(cl[c].sig);
                put32(cl[c].len);
                for (int i = 0; i < int'(cl[c].body); i++) begin
                    if (c == rate_at && i >= 8 && i < 12)
                        file_bytes.push_back(sp.rate[8*(i-8) +: 8]);
                    else
                        file_bytes.push_back(8'($urandom));
                end
            end
        end
        for (int i = 0; i < int'(sp.tail); i++)
            file_bytes.push_back(8'($urandom));
        if (sp.cut != '0)
            while (file_bytes.size() > int'(sp.cut))
                void'(file_bytes.pop_back());
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = gappy ? $urandom_range(1, 8) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_image(input bit fixed_exp, input wav_result_t fixed_res);
        wav_result_t res;
        int          n;
        n     = file_bytes.size();
        gappy = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++) begin
            send_byte(file_bytes[i], i == n - 1);
            if (parse_wav_byte(file_bytes[i], i == n - 1, res))
                pending_durations.push_back(fixed_exp ? fixed_res : res);
        end
        bytes_sent += n;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_durations.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_tick_rate(input logic [TICKS_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tick_rate = v;
    endtask

    // result sink
    initial begin : result_sink
        ready_mode_t mode;
        int          win;
        int          cnt;
        wav_result_t want;
        mode = READY_ALWAYS;
        win  = 0;
        cnt  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_durations.size() == 0) begin
                    $error("unexpected result request: tdata %h", m_tdata);
                    fail_cnt++;
                end else begin
                    want = pending_durations.pop_front();
                    if (m_tdata[2:0] != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[34:3] != want.ticks) begin
                        $error("duration_ticks: expected %0d, got %0d",
                               want.ticks, m_tdata[34:3]);
                        fail_cnt++;
                    end
                end
            end
            if (win == 0) begin
                mode = ready_mode_t'($urandom_range(0, 3));
                win  = $urandom_range(50, 400);
            end
            win--;
            cnt++;
            case (mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_tready <= (cnt % 7 == 0);
                default:      m_tready <= ((cnt & 32) != 0);
            endcase
        end
    end

    initial begin : stimulus
        image_spec_t        dir_tbl[N_DIR];
        image_spec_t        sp;
        logic [TICKS_W-1:0] t;
        logic [31:0]        v;
        int                 phase;
        bit                 fit;

        dir_tbl[0]  = '{TICKS_RESET, TAG_RIFF, 32'd1036, TAG_WAVE, FMT16,
                        ck(TAG_DATA, 1000, 4), NO_CK, 32'd1000, 8'd0, 8'd0,
                        1'b1, STAT_OK, 32'd1000};
        dir_tbl[1]  = dir_tbl[0];
        dir_tbl[1].cut = 8'd31;
        dir_tbl[1].exp_status = STAT_SHORT;
        dir_tbl[1].exp_ticks  = 32'd0;
        dir_tbl[2]  = dir_tbl[1];
        dir_tbl[2].cut = 8'd1;
        dir_tbl[3]  = dir_tbl[1];
        dir_tbl[3].cut = 8'd32;
        dir_tbl[3].exp_status = STAT_NO_DATA;
        dir_tbl[4]  = dir_tbl[0];
        dir_tbl[4].riff_sig = 32'h4646_4953;
        dir_tbl[4].exp_status = STAT_BAD_SIG;
        dir_tbl[4].exp_ticks  = 32'd0;
        dir_tbl[5]  = dir_tbl[4];
        dir_tbl[5].riff_sig = TAG_RIFF;
        dir_tbl[5].wave_sig = 32'h4556_4158;
        dir_tbl[6]  = '{TICKS_RESET, TAG_RIFF, 32'd1036, TAG_WAVE, ck(TAG_DATA, 100, 4),
                        NO_CK, NO_CK, 32'd1000, 8'd16, 8'd0, 1'b1, STAT_NO_FMT, 32'd0};
        dir_tbl[7]  = dir_tbl[0];
        dir_tbl[7].rate = 32'd0;
        dir_tbl[7].exp_status = STAT_NO_FMT;
        dir_tbl[7].exp_ticks  = 32'd0;
        dir_tbl[8]  = '{TICKS_RESET, TAG_RIFF, 32'd1036, TAG_WAVE, FMT16, NO_CK, NO_CK,
                        32'd1000, 8'd12, 8'd0, 1'b1, STAT_NO_DATA, 32'd0};
        // data header ends on the final byte, nothing follows it
        dir_tbl[9]  = dir_tbl[8];
        dir_tbl[9].c1   = ck(TAG_DATA, 1000, 0);
        dir_tbl[9].tail = 8'd0;
        // data header ends right at the RIFF limit
        dir_tbl[10] = dir_tbl[0];
        dir_tbl[10].riff_len = 32'd36;
        dir_tbl[10].exp_status = STAT_NO_DATA;
        dir_tbl[10].exp_ticks  = 32'd0;
        dir_tbl[11] = dir_tbl[0];
        dir_tbl[11].riff_len  = 32'd37;
        dir_tbl[11].fixed_exp = 1'b0;
        // fmt body too short, rate bytes overlap the next header
        dir_tbl[12] = '{TICKS_RESET, TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE, ck(TAG_FMT, 10, 10),
                        ck(TAG_DATA, 500, 4), NO_CK, 32'h0000_7D00, 8'd0, 8'd0,
                        1'b0, STAT_OK, 32'd0};
        // image ends inside the rate field
        dir_tbl[13] = '{TICKS_RESET, TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE, ck(TAG_DATA, 200, 2),
                        ck(TAG_FMT, 16, 9), NO_CK, 32'h0000_0040, 8'd0, 8'd0,
                        1'b0, STAT_OK, 32'd0};
        // rate bytes lie beyond the RIFF limit
        dir_tbl[14] = '{TICKS_RESET, TAG_RIFF, 32'd21, TAG_WAVE, ck(TAG_DATA, 300, 0),
                        FMT16, NO_CK, 32'd44100, 8'd0, 8'd0, 1'b0, STAT_OK, 32'd0};
        dir_tbl[15] = '{TICKS_RESET, TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE, FMT16,
                        ck(TAG_DATA, 40, 40), FMT16, 32'd48000, 8'd2, 8'd0,
                        1'b0, STAT_OK, 32'd0};
        dir_tbl[16] = '{TICKS_RESET, TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE, ck(TAG_DATA, 3, 3),
                        FMT16, ck(TAG_DATA, 5, 1), 32'd8, 8'd0, 8'd0, 1'b0, STAT_OK, 32'd0};
        dir_tbl[17] = '{20'd1000000, TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE, FMT16,
                        ck(TAG_DATA, 32'hFFFF_FFFF, 4), NO_CK, 32'd1, 8'd0, 8'd0,
                        1'b1, STAT_OK, 32'hFFFF_FFFF};
        dir_tbl[18] = '{20'd1000000, TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE, FMT16,
                        ck(TAG_DATA, 1, 4), NO_CK, 32'hFFFF_FFFF, 8'd0, 8'd0,
                        1'b1, STAT_OK, 32'd0};
        dir_tbl[19] = dir_tbl[0];
        dir_tbl[19].ticks     = 20'd0;
        dir_tbl[19].exp_ticks = 32'd0;
        dir_tbl[20] = '{20'd1, TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE, ck(32'h5453_494C, 6, 6),
                        FMT16, ck(TAG_DATA, 32'h0012_3456, 5), 32'd22050, 8'd0, 8'd0,
                        1'b0, STAT_OK, 32'd0};

        clear_parse_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_tbl[r].ticks != tick_rate)
                set_tick_rate(dir_tbl[r].ticks);
            build_image(dir_tbl[r]);
            send_image(dir_tbl[r].fixed_exp, '{dir_tbl[r].exp_status, dir_tbl[r].exp_ticks});
        end

        phase = 0;
        while (phase < 4 || bytes_sent < 1450) begin
            case (phase % 4)
                0:       t = 20'd1000000;
                1:       t = TICKS_W'($urandom_range(1, 1000000));
                2:       t = 20'd1;
                default: t = TICKS_W'($urandom_range(1, 100));
            endcase
            set_tick_rate(t);
            repeat (2) begin
                if ($urandom_range(0, 9) == 0) begin
                    file_bytes.delete();
                    repeat ($urandom_range(1, 80))
                        file_bytes.push_back(8'($urandom));
                end else begin
                    sp          = '0;
                    sp.riff_sig = ($urandom_range(0, 19) == 0) ? 32'($urandom) : TAG_RIFF;
                    sp.wave_sig = ($urandom_range(0, 19) == 0) ? 32'($urandom) : TAG_WAVE;
                    case ($urandom_range(0, 3))
                        0:       sp.riff_len = $urandom;
                        1:       sp.riff_len = $urandom_range(0, 64);
                        default: sp.riff_len = 32'hFFFF_FFFF;
                    endcase
                    fit   = ($urandom_range(0, 2) == 0);
                    sp.c0 = random_chunk(TAG_FMT);
                    sp.c1 = random_chunk(TAG_DATA);
                    sp.c2 = random_chunk('0);
                    case ($urandom_range(0, 9))
                        0:       sp.rate = $urandom;
                        1:       sp.rate = 32'd0;
                        2:       sp.rate = $urandom_range(1, 3);
                        default: sp.rate = $urandom_range(8000, 400000);
                    endcase
                    sp.tail = 8'($urandom_range(0, 3));
                    sp.cut  = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 60)) : 8'd0;
                    build_image(sp);
                    // RIFF size that matches the image
                    if (fit && file_bytes.size() >= 8) begin
                        v = 32'(file_bytes.size() - 8);
                        for (int i = 0; i < 4; i++)
                            file_bytes[4 + i] = v[8*i +: 8];
                    end
                end
                send_image(1'b0, '{STAT_OK, 32'd0});
            end
            phase++;
        end

        wait_drained();
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
